[rtl/rcpqm_pkg.sv]
// shared constants and types for the rc pulse capture and quad-x mixer
// no dependencies; used by rc_pulse_capture_quad_mixer
package rcpqm_pkg;

  // channel count and fixed channel roles
  localparam int NumChannelsDef = 8;
  localparam int ChRoll         = 0;
  localparam int ChThrottle     = 1;
  localparam int ChPitch        = 2;
  localparam int ChFailsafe     = 6;

  // configuration register reset values
  localparam logic [15:0] ThrCenterRst   = 16'd110;
  localparam logic [11:0] ThrGainRst     = 12'd600;
  localparam logic [15:0] RollCenterRst  = 16'd85;
  localparam logic [15:0] PitchCenterRst = 16'd83;
  localparam logic [11:0] StickGainRst   = 12'd100;
  localparam logic [15:0] DeadBandRst    = 16'd400;
  localparam logic [15:0] FsLimitRst     = 16'd70;
  localparam logic [14:0] MotorMaxRst    = 15'd15000;

  // mixer constants
  localparam logic signed [31:0] M1Trim  = 32'sd2500;
  localparam logic signed [31:0] M3Trim  = 32'sd500;
  localparam logic [15:0]        OutBase = 16'd16000;

  typedef enum logic [2:0] {
    CFG_THR_CENTER   = 3'd0,
    CFG_THR_GAIN     = 3'd1,
    CFG_ROLL_CENTER  = 3'd2,
    CFG_PITCH_CENTER = 3'd3,
    CFG_STICK_GAIN   = 3'd4,
    CFG_DEAD_BAND    = 3'd5,
    CFG_FS_LIMIT     = 3'd6,
    CFG_MOTOR_MAX    = 3'd7
  } cfg_idx_e;

endpackage

[rtl/rc_pulse_capture_quad_mixer.sv]
// rc pulse capture with quad-x mixer: pulse width capture on the input request,
// then a two-stage multiply / mix pipeline into an output register
// depends on rcpqm_pkg
//
// m_axis_tvalid_o rises after the state update at the accepting edge, the multiply stage
// and the mix/clamp stage, each registered; throughput: one request per
// cycle, the pipeline stalls as a whole only while the output register holds an untaken result
// reset (async, active low) clears the time counter, pulse starts and widths,
// disarms, empties the pipeline and loads the default configuration
module rc_pulse_capture_quad_mixer #(
  parameter int NUM_CHANNELS = rcpqm_pkg::NumChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [2:0] channel, [3] level, [7:4] zero
  input  logic [0:0]  s_axis_tuser_i,   // [0] kind
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [15:0] compare_one, [31:16] compare_two,
                                        // [47:32] compare_three, [63:48] compare_four
  output logic [0:0]  m_axis_tuser_o,   // [0] armed
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int IdxW = $clog2(NUM_CHANNELS);

  // configuration registers
  logic [15:0] thr_center_q, roll_center_q, pitch_center_q, dead_band_q, fs_limit_q;
  logic [11:0] thr_gain_q, stick_gain_q;
  logic [14:0] motor_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_center_q   <= rcpqm_pkg::ThrCenterRst;
      thr_gain_q     <= rcpqm_pkg::ThrGainRst;
      roll_center_q  <= rcpqm_pkg::RollCenterRst;
      pitch_center_q <= rcpqm_pkg::PitchCenterRst;
      stick_gain_q   <= rcpqm_pkg::StickGainRst;
      dead_band_q    <= rcpqm_pkg::DeadBandRst;
      fs_limit_q     <= rcpqm_pkg::FsLimitRst;
      motor_max_q    <= rcpqm_pkg::MotorMaxRst;
    end else if (cfg_we_i) begin
      unique case (rcpqm_pkg::cfg_idx_e'(cfg_idx_i))
        rcpqm_pkg::CFG_THR_CENTER:   thr_center_q   <= cfg_data_i;
        rcpqm_pkg::CFG_THR_GAIN:     thr_gain_q     <= cfg_data_i[11:0];
        rcpqm_pkg::CFG_ROLL_CENTER:  roll_center_q  <= cfg_data_i;
        rcpqm_pkg::CFG_PITCH_CENTER: pitch_center_q <= cfg_data_i;
        rcpqm_pkg::CFG_STICK_GAIN:   stick_gain_q   <= cfg_data_i[11:0];
        rcpqm_pkg::CFG_DEAD_BAND:    dead_band_q    <= cfg_data_i;
        rcpqm_pkg::CFG_FS_LIMIT:     fs_limit_q     <= cfg_data_i;
        rcpqm_pkg::CFG_MOTOR_MAX:    motor_max_q    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // pipeline control: the whole pipe advances when the output register is empty or its result is taken
  logic adv;
  logic accept;
  logic v1_q, v2_q, out_valid_q;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // capture state
  logic            in_kind, in_level;
  logic [IdxW-1:0] in_ch;
  logic [15:0]     time_q;
  logic [15:0]     start_q [NUM_CHANNELS];
  logic [15:0]     width_q [NUM_CHANNELS];
  logic            armed_q;
  logic [15:0]     new_width;
  logic [15:0]     fs_width_d;

  assign in_kind  = s_axis_tuser_i[0];
  assign in_level = s_axis_tdata_i[3];
  assign in_ch    = IdxW'(s_axis_tdata_i[2:0]);

  assign new_width = time_q - start_q[in_ch];

  // failsafe width as it stands after this edge
  always_comb begin
    fs_width_d = width_q[IdxW'(rcpqm_pkg::ChFailsafe)];
    if (!in_level && (in_ch == IdxW'(rcpqm_pkg::ChFailsafe))) begin
      fs_width_d = new_width;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= '0;
      armed_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_q[i] <= '0;
        width_q[i] <= '0;
      end
    end else if (accept) begin
      if (!in_kind) begin
        time_q <= time_q + 16'd1;
      end else begin
        if (in_level) begin
          start_q[in_ch] <= time_q;
        end else begin
          width_q[in_ch] <= new_width;
        end
        armed_q <= !(fs_width_d > fs_limit_q);
      end
    end
  end

  // multiply stage
  logic signed [16:0] thr_diff, roll_diff, pitch_diff;
  logic signed [29:0] thr_prod, roll_prod, pitch_prod;
  logic [27:0]        thr_q;
  logic signed [29:0] roll_q, pitch_q;
  logic               armed_p_q;

  assign thr_diff   = $signed({1'b0, thr_center_q})
                    - $signed({1'b0, width_q[IdxW'(rcpqm_pkg::ChThrottle)]});
  assign roll_diff  = $signed({1'b0, width_q[IdxW'(rcpqm_pkg::ChRoll)]})
                    - $signed({1'b0, roll_center_q});
  assign pitch_diff = $signed({1'b0, width_q[IdxW'(rcpqm_pkg::ChPitch)]})
                    - $signed({1'b0, pitch_center_q});
  assign thr_prod   = thr_diff * $signed({1'b0, thr_gain_q});
  assign roll_prod  = roll_diff * $signed({1'b0, stick_gain_q});
  assign pitch_prod = pitch_diff * $signed({1'b0, stick_gain_q});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      thr_q     <= thr_prod[29] ? '0 : thr_prod[27:0];
      roll_q    <= roll_prod;
      pitch_q   <= pitch_prod;
      armed_p_q <= armed_q;
    end
  end

  // mix stage
  logic [29:0]        roll_mag, pitch_mag;
  logic               thr_zero;
  logic signed [29:0] roll_eff, pitch_eff;
  logic signed [31:0] thr_s, roll_s, pitch_s;
  logic signed [31:0] m1, m2, m3, m4;

  function automatic logic [15:0] clamp_out(logic signed [31:0] v, logic [14:0] vmax);
    logic [14:0] c;
    if (v[31]) begin
      c = '0;
    end else if (v > $signed({17'd0, vmax})) begin
      c = vmax;
    end else begin
      c = v[14:0];
    end
    return {1'b0, c} + rcpqm_pkg::OutBase;
  endfunction

  assign roll_mag  = roll_q[29] ? 30'(-roll_q) : 30'(roll_q);
  assign pitch_mag = pitch_q[29] ? 30'(-pitch_q) : 30'(pitch_q);
  assign thr_zero  = (thr_q == '0);

  // stick inside the deadband or no throttle gives no attitude command
  assign roll_eff  = (thr_zero || (roll_mag <= {14'd0, dead_band_q})) ? '0 : roll_q;
  assign pitch_eff = (thr_zero || (pitch_mag <= {14'd0, dead_band_q})) ? '0 : pitch_q;

  assign thr_s   = $signed({4'd0, thr_q});
  assign roll_s  = {{2{roll_eff[29]}}, roll_eff};
  assign pitch_s = {{2{pitch_eff[29]}}, pitch_eff};

  always_comb begin
    if (armed_p_q) begin
      m1 = thr_s - pitch_s - roll_s - rcpqm_pkg::M1Trim;
      m2 = thr_s + pitch_s - roll_s;
      m3 = thr_s + pitch_s + roll_s - rcpqm_pkg::M3Trim;
      m4 = thr_s - pitch_s + roll_s;
    end else begin
      m1 = '0;
      m2 = '0;
      m3 = '0;
      m4 = '0;
    end
  end

  logic [63:0] out_data_q;
  logic        out_armed_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q  <= {clamp_out(m4, motor_max_q), clamp_out(m1, motor_max_q),
                      clamp_out(m2, motor_max_q), clamp_out(m3, motor_max_q)};
      out_armed_q <= armed_p_q;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_armed_q;

endmodule

[bench/tb_rc_pulse_capture_quad_mixer.sv]
// testbench for rc_pulse_capture_quad_mixer: drives tick and edge requests and predicts
// every result with a behavioral mixer model; checks all compare values and the armed flag
// depends on rcpqm_pkg and rc_pulse_capture_quad_mixer
`timescale 1ns / 100ps

module tb_rc_pulse_capture_quad_mixer;

  localparam int StallLimit = 2000;

  typedef struct packed {
    logic       kind;
    logic [2:0] channel;
    logic       level;
  } req_t;

  // cmp[0] is compare_one, same order as the packed result bus
  typedef struct packed {
    logic [3:0][15:0] cmp;
    logic             armed;
  } mix_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic [0:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  rc_pulse_capture_quad_mixer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model configuration
  int thr_center  = int'(rcpqm_pkg::ThrCenterRst);
  int thr_gain    = int'(rcpqm_pkg::ThrGainRst);
  int roll_center = int'(rcpqm_pkg::RollCenterRst);
  int pitch_center = int'(rcpqm_pkg::PitchCenterRst);
  int stick_gain  = int'(rcpqm_pkg::StickGainRst);
  int dead_band   = int'(rcpqm_pkg::DeadBandRst);
  int fs_limit    = int'(rcpqm_pkg::FsLimitRst);
  int motor_max   = int'(rcpqm_pkg::MotorMaxRst);

  // model state
  logic [15:0] tick_cnt = '0;
  logic [15:0] start_q [8];
  logic [15:0] width_q [8];
  logic        arm_flag = 1'b0;

  req_t        request_q [$];
  mix_result_t mix_q [$];
  int          items_sent = 0;
  int          err_cnt = 0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;

  initial begin
    foreach (start_q[i]) begin
      start_q[i] = '0;
      width_q[i] = '0;
    end
  end

  function automatic longint stick_term(logic [15:0] w, int center);
    longint v;
    longint mag;
    v = (longint'(w) - center) * stick_gain;
    mag = (v < 0) ? -v : v;
    return (mag <= dead_band) ? 0 : v;
  endfunction

  function automatic logic [15:0] motor_out(longint v);
    if (v < 0) v = 0;
    if (v > motor_max) v = motor_max;
    return 16'(v + longint'(rcpqm_pkg::OutBase));
  endfunction

  // advances the model by one request and queues the result it produces
  function automatic void mix_predict(req_t r);
    longint thr, roll, pitch, m1, m2, m3, m4;
    mix_result_t res;
    if (!r.kind) begin
      tick_cnt = tick_cnt + 16'd1;
    end else begin
      if (r.level) start_q[r.channel] = tick_cnt;
      else width_q[r.channel] = tick_cnt - start_q[r.channel];
      arm_flag = !(longint'(width_q[rcpqm_pkg::ChFailsafe]) > fs_limit);
    end
    thr = (longint'(thr_center) - longint'(width_q[rcpqm_pkg::ChThrottle])) * thr_gain;
    if (thr < 0) thr = 0;
    roll = stick_term(width_q[rcpqm_pkg::ChRoll], roll_center);
    pitch = stick_term(width_q[rcpqm_pkg::ChPitch], pitch_center);
    if (thr == 0) begin
      roll = 0;
      pitch = 0;
    end
    if (arm_flag) begin
      m1 = thr - pitch - roll - rcpqm_pkg::M1Trim;
      m2 = thr + pitch - roll;
      m3 = thr + pitch + roll - rcpqm_pkg::M3Trim;
      m4 = thr - pitch + roll;
    end else begin
      m1 = 0; m2 = 0; m3 = 0; m4 = 0;
    end
    res.cmp[0] = motor_out(m3);
    res.cmp[1] = motor_out(m2);
    res.cmp[2] = motor_out(m1);
    res.cmp[3] = motor_out(m4);
    res.armed = arm_flag;
    mix_q.push_back(res);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : driver
    req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
      in_gap = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        mix_predict('{kind: s_axis_tuser_i[0], channel: s_axis_tdata_i[2:0],
                      level: s_axis_tdata_i[3]});
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (in_gap > 0 && !calm) begin
          in_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          nxt = request_q.pop_front();
          s_axis_tdata_i  <= {4'b0000, nxt.level, nxt.channel};
          s_axis_tuser_i  <= nxt.kind;
          s_axis_tvalid_i <= 1'b1;
          in_gap = pick_gap();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    mix_result_t exp_res;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      out_stall = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (mix_q.size() == 0) begin
          note_error("result with no request outstanding");
        end else begin
          exp_res = mix_q.pop_front();
          for (int i = 0; i < 4; i++)
            if (m_axis_tdata_o[16*i +: 16] !== exp_res.cmp[i])
              note_error($sformatf("compare %0d expected %0d got %0d", i + 1,
                                   exp_res.cmp[i], m_axis_tdata_o[16*i +: 16]));
          if (m_axis_tuser_o[0] !== exp_res.armed)
            note_error($sformatf("armed expected %0b got %0b", exp_res.armed,
                                 m_axis_tuser_o[0]));
        end
      end
      if (out_stall > 0 && !calm) begin
        out_stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_item(logic kind, logic [2:0] ch, logic lvl);
    request_q.push_back('{kind: kind, channel: ch, level: lvl});
    items_sent++;
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_item(1'b0, 3'd0, 1'b0);
  endtask

  task automatic push_pulse(logic [2:0] ch, int w);
    push_item(1'b1, ch, 1'b1);
    push_ticks(w);
    push_item(1'b1, ch, 1'b0);
  endtask

  // one receiver frame; now and then a pulse loses its rising or falling edge or is not sent at all
  task automatic push_frame();
    logic [2:0] chans [5];
    int w;
    int r;
    chans = '{3'(rcpqm_pkg::ChRoll), 3'(rcpqm_pkg::ChThrottle), 3'(rcpqm_pkg::ChPitch),
              3'(rcpqm_pkg::ChFailsafe), 3'($urandom_range(0, 7))};
    foreach (chans[i]) begin
      case (chans[i])
        3'(rcpqm_pkg::ChRoll):     w = roll_center + $urandom_range(0, 16) - 8;
        3'(rcpqm_pkg::ChThrottle): w = $urandom_range(0, thr_center + 3);
        3'(rcpqm_pkg::ChPitch):    w = pitch_center + $urandom_range(0, 16) - 8;
        3'(rcpqm_pkg::ChFailsafe): w = fs_limit + $urandom_range(0, 6) - 4;
        default:                   w = $urandom_range(0, 10);
      endcase
      if (w < 0) w = 0;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        push_item(1'b1, chans[i], 1'b1);
        push_ticks(w);
      end else if (r < 10) begin
        push_ticks(w);
        push_item(1'b1, chans[i], 1'b0);
      end else if (r < 90) begin
        push_pulse(chans[i], w);
      end
      push_ticks($urandom_range(0, 3));
    end
  endtask

  task automatic write_reg(rcpqm_pkg::cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      rcpqm_pkg::CFG_THR_CENTER:   thr_center = int'(val);
      rcpqm_pkg::CFG_THR_GAIN:     thr_gain = int'(val[11:0]);
      rcpqm_pkg::CFG_ROLL_CENTER:  roll_center = int'(val);
      rcpqm_pkg::CFG_PITCH_CENTER: pitch_center = int'(val);
      rcpqm_pkg::CFG_STICK_GAIN:   stick_gain = int'(val[11:0]);
      rcpqm_pkg::CFG_DEAD_BAND:    dead_band = int'(val);
      rcpqm_pkg::CFG_FS_LIMIT:     fs_limit = int'(val);
      rcpqm_pkg::CFG_MOTOR_MAX:    motor_max = int'(val[14:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] tc, logic [15:0] tg, logic [15:0] rc,
                            logic [15:0] pc, logic [15:0] sg, logic [15:0] db,
                            logic [15:0] fl, logic [15:0] mm);
    write_reg(rcpqm_pkg::CFG_THR_CENTER, tc);
    write_reg(rcpqm_pkg::CFG_THR_GAIN, tg);
    write_reg(rcpqm_pkg::CFG_ROLL_CENTER, rc);
    write_reg(rcpqm_pkg::CFG_PITCH_CENTER, pc);
    write_reg(rcpqm_pkg::CFG_STICK_GAIN, sg);
    write_reg(rcpqm_pkg::CFG_DEAD_BAND, db);
    write_reg(rcpqm_pkg::CFG_FS_LIMIT, fl);
    write_reg(rcpqm_pkg::CFG_MOTOR_MAX, mm);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // checked on the falling edge so that all driver updates have settled
  task automatic drain();
    while (request_q.size() != 0 || s_axis_tvalid_i || mix_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration, still disarmed
    push_ticks(2);
    drain();

    // small centers so that short pulses reach every mixer branch
    set_config(16'd4, 16'd3000, 16'd2, 16'd1, 16'd2000, 16'd2000, 16'd1, 16'd15000);
    push_pulse(3'(rcpqm_pkg::ChFailsafe), 0);
    push_pulse(3'(rcpqm_pkg::ChThrottle), 2);
    push_pulse(3'(rcpqm_pkg::ChRoll), 1);
    push_pulse(3'(rcpqm_pkg::ChFailsafe), 2);
    push_pulse(3'(rcpqm_pkg::ChThrottle), 5);
    push_pulse(3'(rcpqm_pkg::ChFailsafe), 0);
    push_item(1'b1, 3'd7, 1'b0);
    drain();

    // roll/pitch center and deadband zero, rest at top, writes wider than the register
    set_config(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    push_pulse(3'(rcpqm_pkg::ChFailsafe), 1);
    push_ticks(1);
    drain();

    // every register at zero
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_pulse(3'(rcpqm_pkg::ChFailsafe), 0);
    push_ticks(1);
    drain();

    repeat (8) begin
      set_config(16'($urandom_range(2, 40)), 16'($urandom()), 16'($urandom_range(0, 30)),
                 16'($urandom_range(0, 30)), 16'($urandom()),
                 16'($urandom_range(0, 20000)), 16'($urandom_range(0, 30)),
                 16'($urandom()));
      calm = ($urandom_range(0, 3) == 0);
      items_sent = 0;
      while (items_sent < 250) begin
        if ($urandom_range(0, 9) < 8)
          push_frame();
        else
          repeat ($urandom_range(1, 6))
            push_item(1'($urandom()), 3'($urandom()), 1'($urandom()));
      end
      drain();
      calm = 1'b0;
    end

    // overlapping pulses on several channels, then a few frames
    set_config(16'd30, 16'd500, 16'd10, 16'd10, 16'd800, 16'd1000, 16'd20, 16'd15000);
    push_item(1'b1, 3'(rcpqm_pkg::ChThrottle), 1'b1);
    push_item(1'b1, 3'(rcpqm_pkg::ChRoll), 1'b1);
    push_ticks(12);
    push_item(1'b1, 3'(rcpqm_pkg::ChThrottle), 1'b0);
    push_item(1'b1, 3'(rcpqm_pkg::ChRoll), 1'b0);
    push_item(1'b1, 3'(rcpqm_pkg::ChPitch), 1'b0);
    push_item(1'b1, 3'(rcpqm_pkg::ChFailsafe), 1'b0);
    repeat (3) push_frame();
    drain();

    repeat (6) @(posedge clk_i);
    if (err_cnt == 0 && mix_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
